// ----- src/rclru_pkg.sv -----
package rclru_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [2:0] OP_USE    = 3'd0;
    localparam logic [2:0] OP_DEFINE = 3'd1;
    localparam logic [2:0] OP_CONST  = 3'd2;
    localparam logic [2:0] OP_FLUSH  = 3'd3;
    localparam logic [2:0] OP_INIT   = 3'd4;

    // Fixed field widths of the stream payloads.
    localparam int OP_W       = 3;
    localparam int TAG_IN_W   = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 32;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 88;
    localparam int M_TUSER_W  = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic init;
        logic lookup;
        logic scan;
        logic commit;
        logic flush_start;
        logic flush_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_init;
        logic is_flush;
        logic is_access;
        logic need_scan;
        logic scan_last;
        logic flush_last;
    } status_t;

    // Increment that stops at the all-ones value.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ----- src/rclru_ctrl.sv -----
module rclru_ctrl
    import rclru_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;
    logic   emit;

    // The output register can take a new result when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (status.is_init) begin
                    cmd.init   = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.is_flush) begin
                    cmd.flush_start = 1'b1;
                    state_next      = ST_FLUSH;
                end else if (status.is_access) begin
                    cmd.lookup = 1'b1;
                    state_next = status.need_scan ? ST_SCAN : ST_COMMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    emit       = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_LOOKUP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    cmd.flush_step = 1'b1;
                    emit           = 1'b1;
                    if (status.flush_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid is set by a new result and cleared when it is taken.
    assign m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- src/rclru_dp.sv -----
module rclru_dp
    import rclru_pkg::*;
#(
    parameter int NUM_SLOTS = 10,
    parameter int TAG_BITS  = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    // Slot store.
    logic [TAG_BITS-1:0]  tag_reg   [NUM_SLOTS];
    logic [TAG_BITS-1:0]  tag_next  [NUM_SLOTS];
    logic [CNT_W-1:0]     stamp_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     stamp_next[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] dirty_reg, dirty_next;
    logic [NUM_SLOTS-1:0] homed_reg, homed_next;

    // Global counters.
    logic [CNT_W-1:0] clock_reg, clock_next;
    logic [CNT_W-1:0] spill_cnt_reg, spill_cnt_next;
    logic [CNT_W-1:0] load_cnt_reg, load_cnt_next;

    // Request and search state.
    logic [OP_W-1:0]     req_op_reg, req_op_next;
    logic [TAG_BITS-1:0] req_tag_reg, req_tag_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]    flush_idx_reg, flush_idx_next;

    // Result register.
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_load_reg, out_load_next;
    logic                out_spill_reg, out_spill_next;
    logic [TAG_IN_W-1:0] out_stag_reg, out_stag_next;
    logic                out_last_reg, out_last_next;
    logic [CNT_W-1:0]    out_stot_reg, out_stot_next;
    logic [CNT_W-1:0]    out_ltot_reg, out_ltot_next;

    // Lookup results.
    logic [NUM_SLOTS-1:0] match;
    logic                 hit_any, free_any, homeless_any;
    logic [IDX_W-1:0]     hit_idx, free_idx, homeless_idx;

    logic [CNT_W-1:0] tag_wide;
    logic [CNT_W-1:0] stag_wide;
    logic [IDX_W-1:0] wb_idx;
    logic             wb_spill;
    logic [CNT_W-1:0] tick;

    assign tag_wide = CNT_W'(s_tdata[TAG_IN_W-1:0]);

    // Parallel tag compare and priority encoders; the lowest index wins.
    always_comb begin
        hit_any      = 1'b0;
        free_any     = 1'b0;
        homeless_any = 1'b0;
        hit_idx      = '0;
        free_idx     = '0;
        homeless_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (tag_reg[i] == req_tag_reg);
            if (match[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (i > 0 && valid_reg[i] && !homed_reg[i]) begin
                homeless_any = 1'b1;
                homeless_idx = IDX_W'(i);
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        status.is_init    = (req_op_reg == OP_INIT);
        status.is_flush   = (req_op_reg == OP_FLUSH);
        status.is_access  = (req_op_reg == OP_USE) || (req_op_reg == OP_DEFINE) ||
                            (req_op_reg == OP_CONST);
        status.need_scan  = !hit_any && !free_any && !homeless_any;
        status.scan_last  = (scan_idx_reg == IDX_W'(NUM_SLOTS - 1));
        status.flush_last = (flush_idx_reg == IDX_W'(NUM_SLOTS - 1));
    end

    // The slot being written back: the commit target or the flush position.
    assign wb_idx    = cmd.flush_step ? flush_idx_reg : target_reg;
    assign wb_spill  = valid_reg[wb_idx] && dirty_reg[wb_idx] && homed_reg[wb_idx];
    assign stag_wide = CNT_W'(tag_reg[wb_idx]);
    assign tick      = sat_inc(clock_reg);

    // Datapath next values.
    always_comb begin
        tag_next       = tag_reg;
        stamp_next     = stamp_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        homed_next     = homed_reg;
        clock_next     = clock_reg;
        spill_cnt_next = spill_cnt_reg;
        load_cnt_next  = load_cnt_reg;
        req_op_next    = req_op_reg;
        req_tag_next   = req_tag_reg;
        hit_next       = hit_reg;
        target_next    = target_reg;
        best_next      = best_reg;
        scan_idx_next  = scan_idx_reg;
        flush_idx_next = flush_idx_reg;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;
        out_load_next  = out_load_reg;
        out_spill_next = out_spill_reg;
        out_stag_next  = out_stag_reg;
        out_last_next  = out_last_reg;
        out_stot_next  = out_stot_reg;
        out_ltot_next  = out_ltot_reg;

        // Latch the incoming transaction.
        if (cmd.capture) begin
            req_op_next  = s_tuser;
            req_tag_next = tag_wide[TAG_BITS-1:0];
        end

        // Pick the hit slot, a free slot or a homeless victim.
        if (cmd.lookup) begin
            hit_next      = hit_any;
            target_next   = hit_any ? hit_idx :
                            free_any ? free_idx :
                            homeless_any ? homeless_idx : '0;
            best_next     = stamp_reg[0];
            scan_idx_next = IDX_W'(1);
        end

        // One stamp compare per cycle for the least recently used slot.
        if (cmd.scan) begin
            if (stamp_reg[scan_idx_reg] < best_reg) begin
                best_next   = stamp_reg[scan_idx_reg];
                target_next = scan_idx_reg;
            end
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        // Update the chosen slot and form the result.
        if (cmd.commit) begin
            clock_next             = tick;
            stamp_next[target_reg] = tick;
            out_slot_next          = SLOT_W'(target_reg);
            out_hit_next           = hit_reg;
            out_last_next          = 1'b1;
            out_load_next          = 1'b0;
            out_spill_next         = 1'b0;
            out_stag_next          = '0;
            out_stot_next          = spill_cnt_reg;
            out_ltot_next          = load_cnt_reg;
            if (hit_reg) begin
                if (req_op_reg == OP_DEFINE) begin
                    dirty_next[target_reg] = 1'b1;
                end
            end else begin
                if (wb_spill) begin
                    out_spill_next = 1'b1;
                    out_stag_next  = stag_wide[TAG_IN_W-1:0];
                    spill_cnt_next = sat_inc(spill_cnt_reg);
                    out_stot_next  = spill_cnt_next;
                end
                if (req_op_reg == OP_USE) begin
                    out_load_next = 1'b1;
                    load_cnt_next = sat_inc(load_cnt_reg);
                    out_ltot_next = load_cnt_next;
                end
                tag_next[target_reg]   = req_tag_reg;
                valid_next[target_reg] = 1'b1;
                dirty_next[target_reg] = (req_op_reg == OP_DEFINE);
                homed_next[target_reg] = (req_op_reg != OP_CONST);
            end
        end

        if (cmd.flush_start) begin
            flush_idx_next = '0;
        end

        // Write back and free one slot per result.
        if (cmd.flush_step) begin
            out_slot_next  = SLOT_W'(flush_idx_reg);
            out_hit_next   = 1'b0;
            out_load_next  = 1'b0;
            out_spill_next = wb_spill;
            out_stag_next  = wb_spill ? stag_wide[TAG_IN_W-1:0] : '0;
            out_last_next  = (flush_idx_reg == IDX_W'(NUM_SLOTS - 1));
            if (wb_spill) begin
                spill_cnt_next = sat_inc(spill_cnt_reg);
            end
            out_stot_next  = spill_cnt_next;
            out_ltot_next  = load_cnt_reg;
            tag_next[flush_idx_reg]   = '0;
            valid_next[flush_idx_reg] = 1'b0;
            dirty_next[flush_idx_reg] = 1'b0;
            homed_next[flush_idx_reg] = 1'b0;
            flush_idx_next            = flush_idx_reg + IDX_W'(1);
        end
    end

    // Cache state and counters; an init clears them as reset does.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.init) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tag_reg[i]   <= '0;
                stamp_reg[i] <= '0;
            end
            valid_reg     <= '0;
            dirty_reg     <= '0;
            homed_reg     <= '0;
            clock_reg     <= '0;
            spill_cnt_reg <= '0;
            load_cnt_reg  <= '0;
        end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tag_reg[i]   <= tag_next[i];
                stamp_reg[i] <= stamp_next[i];
            end
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            homed_reg     <= homed_next;
            clock_reg     <= clock_next;
            spill_cnt_reg <= spill_cnt_next;
            load_cnt_reg  <= load_cnt_next;
        end
    end

    // Request, search and result registers carry payload only.
    always_ff @(posedge aclk) begin
        req_op_reg    <= req_op_next;
        req_tag_reg   <= req_tag_next;
        hit_reg       <= hit_next;
        target_reg    <= target_next;
        best_reg      <= best_next;
        scan_idx_reg  <= scan_idx_next;
        flush_idx_reg <= flush_idx_next;
        out_slot_reg  <= out_slot_next;
        out_hit_reg   <= out_hit_next;
        out_load_reg  <= out_load_next;
        out_spill_reg <= out_spill_next;
        out_stag_reg  <= out_stag_next;
        out_last_reg  <= out_last_next;
        out_stot_reg  <= out_stot_next;
        out_ltot_reg  <= out_ltot_next;
    end

    assign m_tdata = {4'b0, out_ltot_reg, out_stot_reg, out_stag_reg, out_slot_reg};
    assign m_tuser = {out_spill_reg, out_load_reg, out_hit_reg};
    assign m_tlast = out_last_reg;

endmodule

// ----- src/register_cache_lru_spill.sv -----
// Channel | Direction | Contents
// s_      | in        | s_tdata: tag; s_tuser: operation
// m_      | out       | m_tdata: slot, spill_tag, spill_total, load_total;
//         |           | m_tuser: hit, load_needed, spill_needed; m_tlast: last
//
// A use, define or constant goes through lookup, then commit, and the
// next transaction is taken in the commit cycle. A miss with every slot in use
// and no homeless slot adds a one-slot-per-cycle stamp scan before the commit.
// A flush gives one result per cycle after its lookup while the output is not
// stalled, then returns to idle, where the next transaction is taken. An init or
// an unknown operation goes through lookup, then idle, and gives no result.
// Reset is synchronous on aresetn and clears all slots and counters at once.
// Results wait in an output register; a stall holds it and blocks the next commit.
module register_cache_lru_spill
    import rclru_pkg::*;
#(
    parameter int NUM_SLOTS = 10,
    parameter int TAG_BITS  = 16
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] tag
    input  logic [S_TUSER_W-1:0] s_tuser,  // [2:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] slot, [19:4] spill_tag, [51:20] spill_total, [83:52] load_total
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,  // [0] hit, [1] load_needed, [2] spill_needed
    output logic                 m_tlast
);

    cmd_t    cmd;
    status_t status;

    // Sequencer for lookup, scan, commit and flush.
    rclru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Slot store, victim search and result register.
    rclru_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ----- tb/sv/tb_register_cache_lru_spill.sv -----
module tb_register_cache_lru_spill;
    timeunit 1ns;
    timeprecision 1ps;

    import rclru_pkg::*;

    localparam int NSLOTS      = 10;
    localparam int NTAGBITS    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;

    // Operation codes the block does not define; it must drop them silently.
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]          op;
        logic [TAG_IN_W-1:0] tag;
    } request_t;

    typedef struct {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                load;
        logic                spill;
        logic [TAG_IN_W-1:0] spill_tag;
        logic                last;
        logic [CNT_W-1:0]    spill_total;
        logic [CNT_W-1:0]    load_total;
    } grant_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    register_cache_lru_spill #(
        .NUM_SLOTS(NSLOTS),
        .TAG_BITS (NTAGBITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the cache contents.
    logic [TAG_IN_W-1:0] sh_tag   [NSLOTS];
    logic                sh_valid [NSLOTS];
    logic                sh_dirty [NSLOTS];
    logic                sh_homed [NSLOTS];
    logic [CNT_W-1:0]    sh_stamp [NSLOTS];
    logic [CNT_W-1:0]    sh_clock;
    logic [CNT_W-1:0]    sh_spills;
    logic [CNT_W-1:0]    sh_loads;

    request_t pending_q[$];
    grant_t   grant_q[$];

    int  errors     = 0;
    int  cycles     = 0;
    int  n_sent     = 0;
    int  n_results  = 0;
    int  n_hits     = 0;
    int  n_evicts   = 0;
    int  n_flushes  = 0;
    bit  calm       = 1'b0;
    bit  s_quiet    = 1'b0;
    bit  m_quiet    = 1'b0;
    int  s_gap      = 0;
    int  m_stall    = 0;
    logic [TAG_IN_W-1:0] tag_pool[16];

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    task automatic cache_clear();
        for (int i = 0; i < NSLOTS; i++) begin
            sh_tag[i]   = '0;
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_homed[i] = 1'b0;
            sh_stamp[i] = '0;
        end
        sh_clock  = '0;
        sh_spills = '0;
        sh_loads  = '0;
    endtask

    // Works out the results of one accepted request and queues them.
    task automatic cache_predict(input logic [2:0] op, input logic [TAG_IN_W-1:0] tag);
        grant_t           g;
        int               r;
        int               vic;
        bit               found;
        bit               done;
        logic [CNT_W-1:0] oldest;
        r     = -1;
        found = 1'b0;
        if (op == OP_INIT) begin
            cache_clear();
        end else if (op == OP_FLUSH) begin
            n_flushes++;
            for (int i = 0; i < NSLOTS; i++) begin
                g.spill     = sh_valid[i] && sh_dirty[i] && sh_homed[i];
                g.spill_tag = g.spill ? sh_tag[i] : '0;
                if (g.spill)
                    sh_spills = count_up(sh_spills);
                sh_dirty[i]   = 1'b0;
                sh_valid[i]   = 1'b0;
                sh_homed[i]   = 1'b0;
                sh_tag[i]     = '0;
                g.slot        = SLOT_W'(i);
                g.hit         = 1'b0;
                g.load        = 1'b0;
                g.last        = (i == NSLOTS - 1);
                g.spill_total = sh_spills;
                g.load_total  = sh_loads;
                grant_q.push_back(g);
            end
        end else if (op == OP_USE || op == OP_DEFINE || op == OP_CONST) begin
            for (int i = 0; i < NSLOTS; i++) begin
                if (!found && sh_valid[i] && sh_tag[i] == tag) begin
                    found = 1'b1;
                    r     = i;
                end
            end
            g.hit       = found;
            g.load      = 1'b0;
            g.spill     = 1'b0;
            g.spill_tag = '0;
            g.last      = 1'b1;
            if (found) begin
                n_hits++;
                sh_clock    = count_up(sh_clock);
                sh_stamp[r] = sh_clock;
                if (op == OP_DEFINE)
                    sh_dirty[r] = 1'b1;
            end else begin
                for (int i = 0; i < NSLOTS; i++)
                    if (r < 0 && !sh_valid[i])
                        r = i;
                if (r < 0) begin
                    // Full cache: a homeless slot from index 1 up, else the oldest stamp.
                    n_evicts++;
                    vic    = 0;
                    oldest = sh_stamp[0];
                    done   = 1'b0;
                    for (int i = 1; i < NSLOTS; i++) begin
                        if (!done) begin
                            if (sh_valid[i] && !sh_homed[i]) begin
                                vic  = i;
                                done = 1'b1;
                            end else if (sh_stamp[i] < oldest) begin
                                oldest = sh_stamp[i];
                                vic    = i;
                            end
                        end
                    end
                    r = vic;
                    if (sh_valid[r] && sh_dirty[r] && sh_homed[r]) begin
                        g.spill     = 1'b1;
                        g.spill_tag = sh_tag[r];
                        sh_spills   = count_up(sh_spills);
                    end
                end
                sh_tag[r]   = tag;
                sh_valid[r] = 1'b1;
                sh_dirty[r] = (op == OP_DEFINE);
                sh_homed[r] = (op != OP_CONST);
                sh_clock    = count_up(sh_clock);
                sh_stamp[r] = sh_clock;
                if (op == OP_USE) begin
                    g.load   = 1'b1;
                    sh_loads = count_up(sh_loads);
                end
            end
            g.slot        = SLOT_W'(r);
            g.spill_total = sh_spills;
            g.load_total  = sh_loads;
            grant_q.push_back(g);
        end
    endtask

    task automatic queue_item(input logic [2:0] op, input logic [TAG_IN_W-1:0] tag);
        request_t it;
        it.op  = op;
        it.tag = tag;
        pending_q.push_back(it);
    endtask

    // Random requests: mostly tags from a small pool, so hits and evictions are common.
    task automatic queue_random(input int count);
        int               pick;
        logic [2:0]       op;
        logic [TAG_IN_W-1:0] tag;
        for (int n = 0; n < count; n++) begin
            if (n % 120 == 0)
                for (int k = 0; k < 16; k++)
                    tag_pool[k] = TAG_IN_W'($urandom);
            pick = $urandom_range(0, 199);
            if (pick < 84)
                op = OP_USE;
            else if (pick < 134)
                op = OP_DEFINE;
            else if (pick < 184)
                op = OP_CONST;
            else if (pick < 191)
                op = OP_FLUSH;
            else if (pick < 194)
                op = OP_INIT;
            else if (pick < 196)
                op = OP_RSVD5;
            else if (pick < 198)
                op = OP_RSVD6;
            else
                op = OP_RSVD7;
            if ($urandom_range(0, 9) < 8)
                tag = tag_pool[$urandom_range(0, 13)];
            else
                tag = TAG_IN_W'($urandom);
            queue_item(op, tag);
        end
    endtask

    task automatic report(input string name, input logic [CNT_W-1:0] want,
                          input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, grant_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver: takes the pending queue and inserts random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cache_predict(s_tuser, s_tdata);
                n_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // Hold the current transaction until it is taken.
            end else if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                if (!calm && !s_quiet && $urandom_range(0, 4) == 0) begin
                    s_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tuser  <= pending_q[0].op;
                    s_tdata  <= pending_q[0].tag;
                    s_tvalid <= 1'b1;
                    void'(pending_q.pop_front());
                end
            end else begin
                s_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 39) == 0)
                s_quiet = !s_quiet;
        end
    end

    // Result monitor: checks each transaction and applies random back-pressure.
    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (grant_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual slot %0d",
                             $time, m_tdata[3:0]);
                    errors++;
                end else begin
                    want = grant_q.pop_front();
                    report("slot", CNT_W'(want.slot), CNT_W'(m_tdata[3:0]));
                    report("spill_tag", CNT_W'(want.spill_tag), CNT_W'(m_tdata[19:4]));
                    report("spill_total", want.spill_total, m_tdata[51:20]);
                    report("load_total", want.load_total, m_tdata[83:52]);
                    report("tdata padding", '0, CNT_W'(m_tdata[87:84]));
                    report("hit", CNT_W'(want.hit), CNT_W'(m_tuser[0]));
                    report("load_needed", CNT_W'(want.load), CNT_W'(m_tuser[1]));
                    report("spill_needed", CNT_W'(want.spill), CNT_W'(m_tuser[2]));
                    report("last", CNT_W'(want.last), CNT_W'(m_tlast));
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else if (!calm && !m_quiet && $urandom_range(0, 4) == 0) begin
                m_stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
                m_quiet = !m_quiet;
        end
    end

    // Stimulus and end of run.
    initial begin
        cache_clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: tag extremes, hits of each kind, a homeless victim,
        // an oldest-stamp victim with write-back, flush, init and dropped codes.
        queue_item(OP_USE,    16'h0000);
        queue_item(OP_USE,    16'hFFFF);
        queue_item(OP_DEFINE, 16'h1234);
        queue_item(OP_USE,    16'hFFFF);
        queue_item(OP_DEFINE, 16'h0000);
        queue_item(OP_CONST,  16'h00C0);
        queue_item(OP_CONST,  16'h00C0);
        for (int k = 0; k < 6; k++)
            queue_item(OP_USE, 16'h0100 + 16'(k));
        queue_item(OP_USE,    16'h0200);
        queue_item(OP_USE,    16'h0300);
        queue_item(OP_DEFINE, 16'h0400);
        queue_item(OP_DEFINE, 16'hAAAA);
        queue_item(OP_RSVD5,  16'h5555);
        queue_item(OP_FLUSH,  16'h0000);
        queue_item(OP_DEFINE, 16'h8001);
        queue_item(OP_INIT,   16'hFFFF);
        queue_item(OP_RSVD6,  16'h0000);
        queue_item(OP_RSVD7,  16'hFFFF);
        queue_item(OP_FLUSH,  16'hFFFF);
        queue_item(OP_USE,    16'h7FFF);

        // Hold off new requests until every result so far has arrived.
        while (pending_q.size() != 0 || s_tvalid || grant_q.size() != 0)
            @(posedge aclk);
        queue_random(230);
        while (pending_q.size() != 0 || s_tvalid || grant_q.size() != 0)
            @(posedge aclk);
        queue_random(230);

        // The last stretch runs with no gaps and no back-pressure.
        while (pending_q.size() > 40)
            @(posedge aclk);
        calm = 1'b1;
        while (pending_q.size() != 0 || s_tvalid || grant_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (grant_q.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, grant_q.size());
            errors++;
        end
        $display("Sent %0d requests and checked %0d results: %0d hits, %0d full-cache misses,",
                 n_sent, n_results, n_hits, n_evicts);
        $display("%0d flushes, %0d loads and %0d write-backs in the last count; %0d errors.",
                 n_flushes, sh_loads, sh_spills, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rclru_pkg.sv
src/rclru_ctrl.sv
src/rclru_dp.sv
src/register_cache_lru_spill.sv
tb/sv/tb_register_cache_lru_spill.sv
